@@ rtl/core/rft_pkg.sv @@
// Shared types and constants for the rail fence transposer.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package rft_pkg;

  localparam int BYTE_W       = 8;
  localparam int LETTER_W     = 5;
  localparam int OUT_LETTER_W = 7;
  localparam int CFG_W        = 5;

  localparam logic [CFG_W-1:0]  RAIL_COUNT_RESET = 5'd3;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_A    = 8'd65;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z    = 8'd90;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_A    = 8'd97;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z    = 8'd122;

  typedef struct packed {
    logic                is_letter;
    logic [LETTER_W-1:0] letter_idx;
    logic                eom;
  } cmd_t;

  typedef struct packed {
    logic [OUT_LETTER_W-1:0] letter;
    logic                    last;
    logic                    overflowed;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/rail_fence_transposer.sv @@
// Top level of the rail fence transposer: configuration register, front end,
// word queue and back end. Depends on rft_pkg, rft_front, rft_cmd_queue, rft_back.
`default_nettype none

// Message bytes are taken one word per cycle while the back end is collecting
// letters; each word passes through a two-entry queue into the back end.
// On the end-of-message word the back end walks the letter buffer once for each
// of the MAX_RAILS rails, reading each buffered letter and then checking its rail
// tag; the walk waits at a matching letter while a result word is pending and
// pop is held low. Input stalls once the queue fills during that walk. The rail
// count register is written through the cfg channel, which is always ready.
module rail_fence_transposer #(
  parameter int MAX_LETTERS = 64,
  parameter int MAX_RAILS   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [rft_pkg::BYTE_W-1:0]  in_byte,
  input  wire logic                        in_end_of_message,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic [rft_pkg::OUT_LETTER_W-1:0] out_letter,
  output logic                             out_last_letter,
  output logic                             out_overflowed,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rft_pkg::CFG_W-1:0]   cfg_rail_count
);

  logic [rft_pkg::CFG_W-1:0] rail_count_r;
  logic                      q_push;
  logic                      q_full;
  logic                      q_empty;
  logic                      q_pop;
  rft_pkg::cmd_t             q_in_cmd;
  rft_pkg::cmd_t             q_out_cmd;
  logic                      res_valid;
  rft_pkg::result_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rail_count_r <= rft_pkg::RAIL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rail_count_r <= cfg_rail_count;
    end
  end

  rft_front u_front (
    .in_push           (in_push),
    .in_byte           (in_byte),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (q_in_cmd),
    .in_full           (in_full)
  );

  rft_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .empty    (q_empty)
  );

  rft_back #(
    .MAX_LETTERS (MAX_LETTERS),
    .MAX_RAILS   (MAX_RAILS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rail_count (rail_count_r),
    .cmd_valid  (!q_empty),
    .cmd        (q_out_cmd),
    .cmd_pop    (q_pop),
    .out_valid  (res_valid),
    .out_result (res),
    .out_take   (out_pop)
  );

  assign out_empty       = !res_valid;
  assign out_letter      = res.letter;
  assign out_last_letter = res.last;
  assign out_overflowed  = res.overflowed;

endmodule

`default_nettype wire

@@ rtl/core/rft_front.sv @@
// Front end: classifies each incoming byte into a letter index and end marker.
// Depends on rft_pkg.
`default_nettype none

module rft_front (
  input  wire logic                       in_push,
  input  wire logic [rft_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       in_end_of_message,
  input  wire logic                       q_full,
  output logic                            q_push,
  output rft_pkg::cmd_t                   q_cmd,
  output logic                            in_full
);

  logic [rft_pkg::BYTE_W-1:0] offset;

  always_comb begin
    q_cmd.is_letter = 1'b0;
    offset          = '0;
    if (in_byte inside {[rft_pkg::ASCII_UPPER_A:rft_pkg::ASCII_UPPER_Z]}) begin
      q_cmd.is_letter = 1'b1;
      offset          = in_byte - rft_pkg::ASCII_UPPER_A;
    end else if (in_byte inside {[rft_pkg::ASCII_LOWER_A:rft_pkg::ASCII_LOWER_Z]}) begin
      q_cmd.is_letter = 1'b1;
      offset          = in_byte - rft_pkg::ASCII_LOWER_A;
    end
    q_cmd.letter_idx = offset[rft_pkg::LETTER_W-1:0];
    q_cmd.eom        = in_end_of_message;
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

`default_nettype wire

@@ rtl/core/rft_cmd_queue.sv @@
// Two-entry queue of classified words between the front and back ends.
// Depends on rft_pkg.
`default_nettype none

module rft_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire rft_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output rft_pkg::cmd_t      pop_cmd,
  output logic               empty
);

  rft_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rft_back.sv @@
// Back end: zigzag rail tagging, letter buffer and the rail-by-rail emission walk.
// Depends on rft_pkg.
`default_nettype none

module rft_back #(
  parameter int MAX_LETTERS = 64,
  parameter int MAX_RAILS   = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [rft_pkg::CFG_W-1:0] rail_count,
  input  wire logic                      cmd_valid,
  input  wire rft_pkg::cmd_t             cmd,
  output logic                           cmd_pop,
  output logic                           out_valid,
  output rft_pkg::result_t               out_result,
  input  wire logic                      out_take
);

  localparam int AW      = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int CW      = $clog2(MAX_LETTERS + 1);
  localparam int RW      = (MAX_RAILS > 1) ? $clog2(MAX_RAILS) : 1;
  localparam int ENTRY_W = rft_pkg::LETTER_W + RW;
  localparam logic [RW-1:0] RAIL_LAST = RW'(MAX_RAILS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_CHECK = 3'b100
  } walk_state_t;

  walk_state_t state_r, state_nxt;

  logic [ENTRY_W-1:0] mem [MAX_LETTERS];
  logic [ENTRY_W-1:0] rd_entry_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] emitted_r, emitted_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [RW-1:0] cur_rail_r, cur_rail_nxt;
  logic [RW-1:0] walk_rail_r, walk_rail_nxt;
  logic          moving_up_r, moving_up_nxt;
  logic          overflow_r, overflow_nxt;
  logic          out_valid_r, out_valid_nxt;
  rft_pkg::result_t out_data_r;

  logic [RW-1:0] last_rail;
  logic [RW-1:0] r_sel, r_next;
  logic          up_sel;
  logic          wr_en;
  logic          rd_en;
  logic          load_out;
  logic          slot_free;
  logic [rft_pkg::LETTER_W-1:0] rd_letter;
  logic [RW-1:0]                rd_tag;

  assign rd_letter = rd_entry_r[ENTRY_W-1:RW];
  assign rd_tag    = rd_entry_r[RW-1:0];
  assign slot_free = !out_valid_r || out_take;
  assign cmd_pop   = cmd_valid && (state_r == ST_IDLE);

  always_comb begin
    if (rail_count < 5'd2) begin
      last_rail = RW'(1);
    end else if (rail_count > 5'(MAX_RAILS)) begin
      last_rail = RAIL_LAST;
    end else begin
      last_rail = RW'(rail_count - 5'd1);
    end
  end

  always_comb begin
    r_sel  = cur_rail_r;
    up_sel = moving_up_r;
    if (cur_rail_r >= last_rail) begin
      r_sel  = last_rail;
      up_sel = 1'b1;
    end
    if (r_sel == '0) begin
      up_sel = 1'b0;
    end
    r_next = up_sel ? r_sel - RW'(1) : r_sel + RW'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    emitted_nxt   = emitted_r;
    k_nxt         = k_r;
    cur_rail_nxt  = cur_rail_r;
    walk_rail_nxt = walk_rail_r;
    moving_up_nxt = moving_up_r;
    overflow_nxt  = overflow_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          if (cmd.is_letter) begin
            if (count_r == CW'(MAX_LETTERS)) begin
              overflow_nxt = 1'b1;
            end else begin
              wr_en         = 1'b1;
              count_nxt     = count_r + CW'(1);
              cur_rail_nxt  = r_next;
              moving_up_nxt = ((r_next == last_rail) || (r_next == '0)) ? !up_sel : up_sel;
            end
          end
          if (cmd.eom) begin
            state_nxt     = ST_READ;
            k_nxt         = '0;
            walk_rail_nxt = '0;
            emitted_nxt   = '0;
          end
        end
      end
      ST_READ: begin
        if (k_r >= count_r) begin
          if (walk_rail_r == RAIL_LAST) begin
            state_nxt     = ST_IDLE;
            count_nxt     = '0;
            cur_rail_nxt  = '0;
            moving_up_nxt = 1'b0;
            overflow_nxt  = 1'b0;
          end else begin
            walk_rail_nxt = walk_rail_r + RW'(1);
            k_nxt         = '0;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rd_tag != walk_rail_r) begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_READ;
        end else if (slot_free) begin
          load_out    = 1'b1;
          emitted_nxt = emitted_r + CW'(1);
          k_nxt       = k_r + CW'(1);
          state_nxt   = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      emitted_r   <= '0;
      k_r         <= '0;
      cur_rail_r  <= '0;
      walk_rail_r <= '0;
      moving_up_r <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      emitted_r   <= emitted_nxt;
      k_r         <= k_nxt;
      cur_rail_r  <= cur_rail_nxt;
      walk_rail_r <= walk_rail_nxt;
      moving_up_r <= moving_up_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= {cmd.letter_idx, r_sel};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[k_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.letter     <= rft_pkg::OUT_LETTER_W'(rft_pkg::ASCII_UPPER_A)
                             + rft_pkg::OUT_LETTER_W'(rd_letter);
      out_data_r.last       <= ((emitted_r + CW'(1)) == count_r);
      out_data_r.overflowed <= overflow_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_data_r;

endmodule

`default_nettype wire

@@ rtl/core/rft_checker.sv @@
// Port-level checks for the rail fence transposer, bound to its top level.
// Depends on rft_pkg and rail_fence_transposer.
`default_nettype none

module rft_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_empty,
  input wire logic                        out_pop,
  input wire logic [rft_pkg::OUT_LETTER_W-1:0] out_letter,
  input wire logic                        out_last_letter,
  input wire logic                        out_overflowed
);

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result channel not empty after reset");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_letter >= 7'd65) && (out_letter <= 7'd90))
    else $error("result word is not an upper case letter");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_letter)
      && $stable(out_last_letter) && $stable(out_overflowed))
    else $error("stalled result word changed");

  a_overflow_per_message: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && !out_last_letter |=>
      out_empty || (out_overflowed == $past(out_overflowed)))
    else $error("overflow flag changed within a message");

endmodule

bind rail_fence_transposer rft_checker u_rft_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_letter      (out_letter),
  .out_last_letter (out_last_letter),
  .out_overflowed  (out_overflowed)
);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for rail_fence_transposer: directed and random message words go in,
// transposed letters come out and are checked against an in-bench predictor.
// Depends on rft_pkg and the rail_fence_transposer top level only.

module tb;

  localparam int MAX_LETTERS = 64;
  localparam int MAX_RAILS   = 16;
  localparam int DRAIN_WAIT  = 2400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [rft_pkg::BYTE_W-1:0] code;
    logic                       eom;
  } msg_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_push = 1'b0;
  logic                             in_full;
  logic [rft_pkg::BYTE_W-1:0]       in_byte = '0;
  logic                             in_end_of_message = 1'b0;
  logic                             out_empty;
  logic                             out_pop = 1'b0;
  logic [rft_pkg::OUT_LETTER_W-1:0] out_letter;
  logic                             out_last_letter;
  logic                             out_overflowed;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rft_pkg::CFG_W-1:0]        cfg_rail_count = rft_pkg::RAIL_COUNT_RESET;

  rail_fence_transposer #(
    .MAX_LETTERS(MAX_LETTERS),
    .MAX_RAILS  (MAX_RAILS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_byte          (in_byte),
    .in_end_of_message(in_end_of_message),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_letter       (out_letter),
    .out_last_letter  (out_last_letter),
    .out_overflowed   (out_overflowed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_rail_count   (cfg_rail_count)
  );

  msg_word_t        pending_words[$];
  rft_pkg::result_t expected_letters[$];

  logic [rft_pkg::LETTER_W-1:0] held_letters [MAX_LETTERS];
  logic [3:0]                   held_rails [MAX_LETTERS];
  int                           held_count = 0;
  int                           zig_rail = 0;
  logic                         zig_up = 1'b0;
  logic                         spill_seen = 1'b0;
  logic [rft_pkg::CFG_W-1:0]    rails_setting = rft_pkg::RAIL_COUNT_RESET;

  int   words_queued = 0;
  int   words_taken = 0;
  int   messages_closed = 0;
  int   spilled_messages = 0;
  int   letters_checked = 0;
  int   rail_writes = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   long_hold = 0;
  logic hold_done = 1'b0;
  logic calm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("Mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic int live_rails();
    int r;
    r = rails_setting;
    if (r < 2) r = 2;
    if (r > MAX_RAILS) r = MAX_RAILS;
    return r;
  endfunction

  // Letters take the next zigzag rail; the end word releases them rail by rail.
  task automatic fold_word(input logic [rft_pkg::BYTE_W-1:0] code, input logic eom);
    logic                         is_letter;
    logic [rft_pkg::LETTER_W-1:0] idx;
    logic [rft_pkg::BYTE_W-1:0]   wide;
    rft_pkg::result_t             res;
    int                           top;
    int                           r;
    int                           nxt;
    int                           rank;
    int                           rail;
    int                           k;
    is_letter = 1'b0;
    idx = '0;
    if (code >= rft_pkg::ASCII_UPPER_A && code <= rft_pkg::ASCII_UPPER_Z) begin
      is_letter = 1'b1;
      wide = code - rft_pkg::ASCII_UPPER_A;
      idx = wide[rft_pkg::LETTER_W-1:0];
    end else if (code >= rft_pkg::ASCII_LOWER_A && code <= rft_pkg::ASCII_LOWER_Z) begin
      is_letter = 1'b1;
      wide = code - rft_pkg::ASCII_LOWER_A;
      idx = wide[rft_pkg::LETTER_W-1:0];
    end
    if (is_letter) begin
      if (held_count >= MAX_LETTERS) begin
        spill_seen = 1'b1;
      end else begin
        top = live_rails() - 1;
        r = zig_rail;
        if (r >= top) begin
          r = top;
          zig_up = 1'b1;
        end
        if (r == 0) zig_up = 1'b0;
        held_letters[held_count] = idx;
        held_rails[held_count] = r[3:0];
        held_count++;
        nxt = zig_up ? r - 1 : r + 1;
        if (nxt == top || nxt == 0) zig_up = ~zig_up;
        zig_rail = nxt;
      end
    end
    if (eom) begin
      rank = 0;
      for (rail = 0; rail < MAX_RAILS; rail++) begin
        for (k = 0; k < held_count; k++) begin
          if (held_rails[k] == rail) begin
            wide = rft_pkg::ASCII_UPPER_A + held_letters[k];
            res.letter = wide[rft_pkg::OUT_LETTER_W-1:0];
            res.last = (rank + 1 == held_count);
            res.overflowed = spill_seen;
            expected_letters.push_back(res);
            rank++;
          end
        end
      end
      messages_closed++;
      if (spill_seen) spilled_messages++;
      held_count = 0;
      zig_rail = 0;
      zig_up = 1'b0;
      spill_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_byte <= '0;
      in_end_of_message <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_push && !in_full) begin
        fold_word(in_byte, in_end_of_message);
        words_taken++;
      end
      if (!in_push || !in_full) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_push <= 1'b0;
        end else if (pending_words.size() != 0) begin
          msg_word_t w;
          w = pending_words.pop_front();
          in_push <= 1'b1;
          in_byte <= w.code;
          in_end_of_message <= w.eom;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      recv_gap = 0;
      long_hold = 0;
    end else begin
      if (out_pop && !out_empty) begin
        letters_checked++;
        if (expected_letters.size() == 0) begin
          flag_mismatch($sformatf("letter %0d arrived with nothing expected", out_letter));
        end else begin
          rft_pkg::result_t want;
          want = expected_letters.pop_front();
          if (out_letter !== want.letter)
            flag_mismatch($sformatf("letter %0d, expected %0d", out_letter, want.letter));
          if (out_last_letter !== want.last)
            flag_mismatch($sformatf("last flag %b, expected %b", out_last_letter, want.last));
          if (out_overflowed !== want.overflowed)
            flag_mismatch($sformatf("overflow flag %b, expected %b", out_overflowed,
                                    want.overflowed));
        end
      end
      // One long stall while words keep coming, so that the input backs up.
      if (long_hold > 0) begin
        long_hold--;
        out_pop <= 1'b0;
      end else if (!hold_done && expected_letters.size() >= 24 &&
                   words_queued - words_taken > 4) begin
        hold_done = 1'b1;
        long_hold = 400;
        out_pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 16);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  function automatic void queue_word(input logic [rft_pkg::BYTE_W-1:0] code, input logic eom);
    msg_word_t w;
    w.code = code;
    w.eom = eom;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic void queue_text(input string s, input logic close);
    int i;
    for (i = 0; i < s.len(); i++) queue_word(s[i], close && i == s.len() - 1);
  endfunction

  function automatic void queue_message(input int n_items, input int noise_pct,
                                        input logic close);
    logic [rft_pkg::BYTE_W-1:0] code;
    int                         i;
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(1, 100) <= noise_pct)
        code = rft_pkg::BYTE_W'($urandom_range(0, 255));
      else if ($urandom_range(0, 1) == 1)
        code = rft_pkg::ASCII_UPPER_A + rft_pkg::BYTE_W'($urandom_range(0, 25));
      else
        code = rft_pkg::ASCII_LOWER_A + rft_pkg::BYTE_W'($urandom_range(0, 25));
      queue_word(code, close && i == n_items - 1);
    end
  endfunction

  function automatic void queue_messages(input int budget, input logic leave_open);
    int left;
    int n;
    left = budget;
    while (left > 0) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (n > left) n = left;
      left -= n;
      queue_message(n, 15, !(leave_open && left == 0));
    end
  endfunction

  task automatic wait_drained();
    while (words_taken != words_queued || expected_letters.size() != 0) @(posedge clk);
  endtask

  task automatic set_rails(input logic [rft_pkg::CFG_W-1:0] value);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_rail_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rails_setting = value;
    rail_writes++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    queue_text("Az@[", 1'b0);
    queue_word(8'h60, 1'b0);
    queue_text("{", 1'b0);
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h80, 1'b0);
    queue_text("Zam", 1'b1);
    queue_text("Hi!", 1'b1);
    queue_text(".", 1'b1);
    queue_text("Q", 1'b1);
    queue_messages(20, 1'b0);

    set_rails(5'd2);
    queue_messages(26, 1'b1);
    set_rails(5'd16);
    queue_messages(20, 1'b0);
    queue_message(70, 0, 1'b1);
    queue_messages(24, 1'b1);
    set_rails(5'd0);
    queue_messages(25, 1'b0);
    set_rails(5'd31);
    queue_messages(25, 1'b1);
    set_rails(5'd17);
    queue_messages(25, 1'b0);
    set_rails(5'd1);
    queue_messages(20, 1'b1);
    set_rails(rft_pkg::CFG_W'($urandom_range(2, 16)));
    queue_messages(20, 1'b0);
    calm = 1'b1;
    set_rails(rft_pkg::CFG_W'($urandom_range(0, 31)));
    queue_messages(20, 1'b0);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_letters.size() != 0)
      flag_mismatch($sformatf("%0d letters never arrived", expected_letters.size()));
    $display("Sent %0d words in %0d messages (%0d overflowed) over %0d rail settings.",
             words_taken, messages_closed, spilled_messages, rail_writes + 1);
    $display("Checked %0d transposed letters, %0d mismatches.", letters_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
